// File: hw/rtl/fra_pkg.sv
// shared types and constants for the font rom address calculator
package fra_pkg;

	localparam int unsigned ADDR_W  = 18;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned IDX_W   = 13;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] char_code;
	} in_beat_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  rom_address;
		logic [COUNT_W-1:0] byte_count;
		logic               found;
	} out_beat_t;

	localparam logic [2:0] FONT_ASCII_5X7   = 3'd0;
	localparam logic [2:0] FONT_ASCII_7X8   = 3'd1;
	localparam logic [2:0] FONT_ASCII_8X16  = 3'd2;
	localparam logic [2:0] FONT_ASCII_8X16B = 3'd3;
	localparam logic [2:0] FONT_ASCII_ARIAL = 3'd4;
	localparam logic [2:0] FONT_ASCII_T16   = 3'd5;
	localparam logic [2:0] FONT_GB2312      = 3'd6;
	localparam logic [2:0] FONT_GB_EXT      = 3'd7;

	localparam logic [ADDR_W-1:0] BASE_5X7   = 18'h3BFC0;
	localparam logic [ADDR_W-1:0] BASE_7X8   = 18'h066C0;
	localparam logic [ADDR_W-1:0] BASE_8X16  = 18'h3B7C0;
	localparam logic [ADDR_W-1:0] BASE_8X16B = 18'h3CF80;
	localparam logic [ADDR_W-1:0] BASE_ARIAL = 18'h3C2C2;
	localparam logic [ADDR_W-1:0] BASE_T16   = 18'h3D582;
	localparam logic [ADDR_W-1:0] BASE_GBEXT = 18'h3B7D0;

	localparam logic [7:0] ASCII_FIRST = 8'h20;
	localparam logic [7:0] ASCII_LAST  = 8'h7E;
	localparam logic [7:0] GB_LO_FIRST = 8'hA1;
	localparam logic [7:0] GB_LO_LAST  = 8'hFE;
	localparam logic [7:0] GB_SYM_FIRST = 8'hA1;
	localparam logic [7:0] GB_SYM_LAST  = 8'hA3;
	localparam logic [7:0] GB_ROW_A9    = 8'hA9;
	localparam logic [7:0] GB_HZ_FIRST  = 8'hB0;
	localparam logic [7:0] GB_HZ_LAST   = 8'hF7;
	localparam logic [7:0] EXT_ROW_A    = 8'hAA;
	localparam logic [7:0] EXT_ROW_B    = 8'hAB;
	localparam logic [7:0] EXT_B_LAST   = 8'hC0;

	localparam logic [IDX_W-1:0] GB_ROW_LEN  = 13'd94;
	localparam logic [IDX_W-1:0] GB_A9_BASE  = 13'd282;
	localparam logic [IDX_W-1:0] GB_HZ_BASE  = 13'd846;
	localparam logic [6:0]       EXT_B_SKIP  = 7'd95;

	localparam logic [COUNT_W-1:0] COUNT_8  = 6'd8;
	localparam logic [COUNT_W-1:0] COUNT_16 = 6'd16;
	localparam logic [COUNT_W-1:0] COUNT_32 = 6'd32;

endpackage

// File: hw/rtl/fra_calc.sv
// glyph address, byte count and found flag from font select and code
module fra_calc (
	input  fra_pkg::in_beat_t  req,
	output fra_pkg::out_beat_t rsp
);

	logic [7:0]                   hi;
	logic [7:0]                   lo;
	logic [6:0]                   asc_idx;
	logic                         asc_hit;
	logic [17:0]                  asc_x8;
	logic [17:0]                  asc_x16;
	logic [17:0]                  asc_x34;
	logic [6:0]                   gb_lo_off;
	logic                         gb_lo_hit;
	logic [6:0]                   gb_row;
	logic [fra_pkg::IDX_W-1:0]    gb_base;
	logic                         gb_row_hit;
	logic [fra_pkg::IDX_W-1:0]    gb_idx;
	logic [6:0]                   ext_idx;
	logic                         ext_hit;

	assign hi = req.char_code[15:8];
	assign lo = req.char_code[7:0];

	assign asc_hit = (lo >= fra_pkg::ASCII_FIRST) && (lo <= fra_pkg::ASCII_LAST);
	assign asc_idx = 7'(lo - fra_pkg::ASCII_FIRST);
	assign asc_x8  = 18'({asc_idx, 3'b000});
	assign asc_x16 = 18'({asc_idx, 4'b0000});
	assign asc_x34 = 18'({asc_idx, 5'b00000}) + 18'({asc_idx, 1'b0});

	assign gb_lo_hit = (lo >= fra_pkg::GB_LO_FIRST) && (lo <= fra_pkg::GB_LO_LAST);
	assign gb_lo_off = 7'(lo - fra_pkg::GB_LO_FIRST);

	always_comb begin
		gb_row     = '0;
		gb_base    = '0;
		gb_row_hit = 1'b0;
		if (hi == fra_pkg::GB_ROW_A9) begin
			gb_base    = fra_pkg::GB_A9_BASE;
			gb_row_hit = 1'b1;
		end else if (hi >= fra_pkg::GB_SYM_FIRST && hi <= fra_pkg::GB_SYM_LAST) begin
			gb_row     = 7'(hi - fra_pkg::GB_SYM_FIRST);
			gb_row_hit = 1'b1;
		end else if (hi >= fra_pkg::GB_HZ_FIRST && hi <= fra_pkg::GB_HZ_LAST) begin
			gb_row     = 7'(hi - fra_pkg::GB_HZ_FIRST);
			gb_base    = fra_pkg::GB_HZ_BASE;
			gb_row_hit = 1'b1;
		end
	end

	assign gb_idx = 13'(gb_row) * fra_pkg::GB_ROW_LEN + 13'(gb_lo_off) + gb_base;

	always_comb begin
		ext_hit = 1'b0;
		ext_idx = '0;
		if (hi == fra_pkg::EXT_ROW_A && gb_lo_hit) begin
			ext_hit = 1'b1;
			ext_idx = gb_lo_off;
		end else if (hi == fra_pkg::EXT_ROW_B && lo >= fra_pkg::GB_LO_FIRST
				&& lo <= fra_pkg::EXT_B_LAST) begin
			ext_hit = 1'b1;
			ext_idx = gb_lo_off + fra_pkg::EXT_B_SKIP;
		end
	end

	always_comb begin
		rsp = '0;
		case (req.command)
			fra_pkg::FONT_ASCII_5X7: begin
				rsp.rom_address = asc_x8 + fra_pkg::BASE_5X7;
				rsp.byte_count  = fra_pkg::COUNT_8;
				rsp.found       = asc_hit;
			end
			fra_pkg::FONT_ASCII_7X8: begin
				rsp.rom_address = asc_x8 + fra_pkg::BASE_7X8;
				rsp.byte_count  = fra_pkg::COUNT_8;
				rsp.found       = asc_hit;
			end
			fra_pkg::FONT_ASCII_8X16: begin
				rsp.rom_address = asc_x16 + fra_pkg::BASE_8X16;
				rsp.byte_count  = fra_pkg::COUNT_16;
				rsp.found       = asc_hit;
			end
			fra_pkg::FONT_ASCII_8X16B: begin
				rsp.rom_address = asc_x16 + fra_pkg::BASE_8X16B;
				rsp.byte_count  = fra_pkg::COUNT_16;
				rsp.found       = asc_hit;
			end
			fra_pkg::FONT_ASCII_ARIAL: begin
				rsp.rom_address = asc_x34 + fra_pkg::BASE_ARIAL;
				rsp.byte_count  = fra_pkg::COUNT_32;
				rsp.found       = asc_hit;
			end
			fra_pkg::FONT_ASCII_T16: begin
				rsp.rom_address = asc_x34 + fra_pkg::BASE_T16;
				rsp.byte_count  = fra_pkg::COUNT_32;
				rsp.found       = asc_hit;
			end
			fra_pkg::FONT_GB2312: begin
				rsp.rom_address = 18'({gb_idx, 5'b00000});
				rsp.byte_count  = fra_pkg::COUNT_32;
				rsp.found       = gb_lo_hit && gb_row_hit;
			end
			fra_pkg::FONT_GB_EXT: begin
				rsp.rom_address = 18'({ext_idx, 4'b0000}) + fra_pkg::BASE_GBEXT;
				rsp.byte_count  = fra_pkg::COUNT_16;
				rsp.found       = ext_hit;
			end
			default: begin
				rsp = '0;
			end
		endcase
		if (!rsp.found) begin
			rsp = '0;
		end
	end

endmodule

// File: hw/rtl/font_rom_address_calc_unit.sv
// font rom address calculator top level: input register, lookup, result register
// an accepted beat is held in the input register, then its lookup result is held in the result register
// throughput: one beat per cycle while out_ready stays high; in_ready follows out_ready through the two stages
// the input and result registers each hold one beat, so one more input beat is
// taken while a finished result waits
// reset: arst_n clears both stage valid flags; payload registers are not reset
module font_rom_address_calc_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fra_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fra_pkg::out_beat_t out_data
);

	logic               valid_s1;
	fra_pkg::in_beat_t  req_s1;
	logic               valid_s2;
	fra_pkg::out_beat_t rsp_s2;
	fra_pkg::out_beat_t rsp_comb;
	logic               load_s2;
	logic               load_s1;

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;
	assign load_s1  = in_valid && in_ready;

	fra_calc u_calc (
		.req (req_s1),
		.rsp (rsp_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= in_data;
		end
		if (load_s2) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = rsp_s2;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp_s2.found |-> rsp_s2.rom_address == '0 && rsp_s2.byte_count == '0)
		else $error("miss beat carries nonzero address or count");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.found |-> rsp_s2.byte_count == fra_pkg::COUNT_8
			|| rsp_s2.byte_count == fra_pkg::COUNT_16 || rsp_s2.byte_count == fra_pkg::COUNT_32)
		else $error("hit beat has bad byte count");

	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted beat not held in stage one");

	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> valid_s2)
		else $error("stage one beat lost on the way to stage two");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(req_s1))
		else $error("stalled stage one beat changed");

endmodule
